FILE: rtl/core/gbps_pkg.sv
// Package for the grid path search block: payload structs and grid constants.
// Used by grid_bidirectional_path_search; depends on nothing.
package gbps_pkg;

  localparam int GRID_ROWS = 8;
  localparam int GRID_COLS = 8;
  localparam logic [3:0] WALK_CODE = 4'd9;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic [3:0] cell_code;
    logic [2:0] goal_row;
    logic [2:0] goal_col;
  } in_item_t;

  typedef struct packed {
    logic [2:0] path_row;
    logic [2:0] path_col;
    logic       found;
    logic       last;
  } out_item_t;

  // A cell code lets the search pass through when it is 0 or 9.
  function automatic logic is_walk(input logic [3:0] code);
    is_walk = (code == 4'd0) || (code == WALK_CODE);
  endfunction

endpackage

FILE: rtl/core/grid_bidirectional_path_search.sv
// Top level of the bidirectional greedy best-first grid path search.
// Depends on gbps_pkg for the payload structs and grid constants.
//
//   channel | signals                      | direction
//   in      | in_valid, in_ready, in_data  | item into the block
//   out     | out_valid, out_ready, out_data | result out of the block
//
// A write command updates one grid cell. A search first clears the marks of all
// 64 cells, then each frontier pop scans its queue memory one entry per cycle
// and re-reads the popped cell; each neighbor takes a memory read-modify-write.
// The path walk then follows the parent chains cell by cell. The queue scan
// dominates the search time. Reset is synchronous; all 64 grid cells clear
// after reset before the first item is taken. Results wait in an output
// register; a stalled output holds the sequencer.
module grid_bidirectional_path_search
  import gbps_pkg::*;
#(
  parameter int ROWS = GRID_ROWS,
  parameter int COLS = GRID_COLS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CELLS = 64;

  localparam logic [4:0] S_INIT = 5'd0, S_IDLE = 5'd1, S_CLR = 5'd2, S_POP = 5'd3,
    S_POPW = 5'd4, S_POPD = 5'd5, S_NB = 5'd6, S_NBR = 5'd7, S_NBW = 5'd8,
    S_FAIL = 5'd9, S_WF = 5'd10, S_WFR = 5'd11, S_WB = 5'd12, S_WBR = 5'd13,
    S_EMIT = 5'd14, S_EMITR = 5'd15, S_WAIT = 5'd16;

  // Memories: grid codes, parent links with mark, frontiers, path buffer.
  logic [3:0] grid_mem [CELLS];
  logic [6:0] fpar_mem [CELLS];
  logic [6:0] bpar_mem [CELLS];
  logic [11:0] fq_mem [CELLS];
  logic [11:0] bq_mem [CELLS];
  logic [5:0] path_mem [CELLS];

  logic [4:0] state;
  logic [5:0] cnt;
  logic [6:0] fq_cnt, bq_cnt;
  logic [63:0] fq_taken, bq_taken;
  logic side;
  logic [5:0] start, goal, cur, nb, meet, walk;
  logic [1:0] dir;
  logic [6:0] scan, path_len, emit_i;
  logic [6:0] best_idx;
  logic [4:0] best_cost;
  logic [3:0] grid_rd;
  logic [6:0] fpar_rd, bpar_rd;
  logic [11:0] q_rd;
  logic [5:0] path_rd;
  logic [6:0] scan_prev;
  logic       scan_pv;

  wire [2:0] cur_r = cur[5:3];
  wire [2:0] cur_c = cur[2:0];

  // Candidate neighbor for the current direction and whether it exists.
  logic [5:0] nb_cell;
  logic       nb_ok;
  always_comb begin
    nb_cell = cur;
    nb_ok = 1'b0;
    case (dir)
      2'd0: begin nb_cell = cur - 6'd8; nb_ok = cur_r != 3'd0; end
      2'd1: begin nb_cell = cur - 6'd1; nb_ok = cur_c != 3'd0; end
      2'd2: begin nb_cell = cur + 6'd1; nb_ok = 32'(cur_c) + 1 < COLS; end
      default: begin nb_cell = cur + 6'd8; nb_ok = 32'(cur_r) + 1 < ROWS; end
    endcase
  end

  function automatic logic [3:0] adiff(input logic [2:0] a, input logic [2:0] b);
    adiff = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  wire [5:0] tgt = side ? start : goal;
  wire [4:0] nb_cost = 5'(adiff(nb[5:3], tgt[5:3])) + 5'(adiff(nb[2:0], tgt[2:0]));
  wire [6:0] own_rd = side ? bpar_rd : fpar_rd;
  wire [6:0] oth_rd = side ? fpar_rd : bpar_rd;
  wire [6:0] q_cnt = side ? bq_cnt : fq_cnt;
  wire       q_taken = side ? bq_taken[scan_prev[5:0]] : fq_taken[scan_prev[5:0]];

  wire [5:0] in_cell = {in_data.cell_row, in_data.cell_col};
  wire [5:0] in_goal = {in_data.goal_row, in_data.goal_col};
  wire in_bad = 32'(in_data.cell_row) >= ROWS || 32'(in_data.cell_col) >= COLS ||
                32'(in_data.goal_row) >= ROWS || 32'(in_data.goal_col) >= COLS;

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Synchronous memory reads, one address per memory per cycle.
  always_ff @(posedge clk) begin
    grid_rd <= grid_mem[nb_cell];
    fpar_rd <= fpar_mem[(state == S_WF || state == S_WFR) ? walk : nb];
    bpar_rd <= bpar_mem[(state == S_WB || state == S_WBR) ? walk : nb];
    q_rd    <= side ? bq_mem[scan[5:0]] : fq_mem[scan[5:0]];
    path_rd <= path_mem[emit_i[5:0]];
  end

  // Sequencer: grid init, writes, clear, pop, expand, trace back, emit or fail.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
      out_valid <= 1'b0;
      fq_cnt <= '0;
      bq_cnt <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_INIT: begin
          grid_mem[cnt] <= 4'd0;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_data.command == CMD_WRITE) begin
              if (32'(in_data.cell_row) < ROWS && 32'(in_data.cell_col) < COLS)
                grid_mem[in_cell] <= in_data.cell_code;
            end else if (in_bad || in_cell == in_goal) begin
              state <= S_FAIL;
            end else begin
              start <= in_cell;
              goal <= in_goal;
              cnt <= '0;
              state <= S_CLR;
            end
          end
        end
        S_CLR: begin
          fpar_mem[cnt] <= (cnt == start) ? {1'b1, start} : 7'd0;
          bpar_mem[cnt] <= (cnt == goal) ? {1'b1, goal} : 7'd0;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            fq_mem[0] <= {6'd0, start};
            bq_mem[0] <= {6'd0, goal};
            fq_cnt <= 7'd1;
            bq_cnt <= 7'd1;
            fq_taken <= '0;
            bq_taken <= '0;
            side <= 1'b0;
            state <= S_POP;
          end
        end
        S_POP: begin
          scan <= '0;
          scan_pv <= 1'b0;
          best_idx <= 7'h7f;
          best_cost <= '1;
          state <= S_POPW;
        end
        S_POPW: begin
          // One queue entry per cycle; the read is registered, so the compare trails the scan by one entry.
          if (scan_pv && !q_taken && (best_idx[6] || {1'b0, q_rd[11:6]} < 7'(best_cost))) begin
            best_idx <= scan_prev;
            best_cost <= q_rd[10:6];
          end
          scan_prev <= scan;
          scan_pv <= scan < q_cnt;
          if (scan >= q_cnt && !scan_pv) state <= S_POPD;
          else if (scan < q_cnt) scan <= scan + 7'd1;
        end
        S_POPD: begin
          if (best_idx[6]) begin
            state <= S_FAIL;
          end else begin
            if (side) bq_taken[best_idx[5:0]] <= 1'b1;
            else fq_taken[best_idx[5:0]] <= 1'b1;
            scan <= best_idx;
            state <= S_NB;
            cnt <= 6'd1;
          end
        end
        S_NB: begin
          // First pass re-reads the popped entry's cell.
          if (cnt == 6'd1) begin
            cnt <= 6'd2;
          end else if (cnt == 6'd2) begin
            cur <= q_rd[5:0];
            dir <= 2'd0;
            cnt <= 6'd0;
          end else if (nb_ok) begin
            nb <= nb_cell;
            state <= S_NBR;
            cnt <= 6'd3;
          end else begin
            cnt <= 6'd0;
            if (dir == 2'd3) begin
              side <= !side;
              state <= S_POP;
            end else dir <= dir + 2'd1;
          end
        end
        S_NBR: begin
          if (cnt == 6'd3) cnt <= 6'd4;
          else state <= S_NBW;
        end
        S_NBW: begin
          cnt <= 6'd0;
          if (is_walk(grid_rd) && !own_rd[6]) begin
            if (side) begin
              bpar_mem[nb] <= {1'b1, cur};
              bq_mem[bq_cnt[5:0]] <= {1'b0, nb_cost, nb};
              bq_cnt <= bq_cnt + 7'd1;
            end else begin
              fpar_mem[nb] <= {1'b1, cur};
              fq_mem[fq_cnt[5:0]] <= {1'b0, nb_cost, nb};
              fq_cnt <= fq_cnt + 7'd1;
            end
          end
          // A walkable neighbor marked by the other side ends the search.
          if (is_walk(grid_rd) && oth_rd[6]) begin
            meet <= nb;
            walk <= nb;
            path_len <= '0;
            state <= S_WF;
          end else if (dir == 2'd3) begin
            side <= !side;
            state <= S_POP;
          end else begin
            dir <= dir + 2'd1;
            state <= S_NB;
          end
        end
        S_WF: state <= S_WFR;
        S_WFR: begin
          // Forward chain, stored reversed from slot 63 downward.
          if (fpar_rd[5:0] != walk) begin
            path_mem[6'd63 - path_len[5:0]] <= walk;
            path_len <= path_len + 7'd1;
            walk <= fpar_rd[5:0];
            state <= S_WF;
          end else begin
            walk <= meet;
            emit_i <= 7'd64 - path_len;
            scan <= path_len;
            state <= S_WB;
          end
        end
        S_WB: begin
          if (walk == goal) begin
            state <= S_EMITR;
          end else state <= S_WBR;
        end
        S_WBR: begin
          path_mem[scan[5:0] - path_len[5:0]] <= bpar_rd[5:0];
          scan <= scan + 7'd1;
          walk <= bpar_rd[5:0];
          state <= S_WB;
        end
        S_EMITR: begin
          if (!out_valid || out_ready) state <= S_EMIT;
        end
        S_EMIT: begin
          // Forward part sits at 64-n..63, backward part at 0..m-1.
          out_valid <= 1'b1;
          out_data.path_row <= path_rd[5:3];
          out_data.path_col <= path_rd[2:0];
          out_data.found <= 1'b1;
          out_data.last <= (emit_i[5:0] == 6'(scan - path_len - 7'd1)) &&
                           (scan != path_len || emit_i == 7'd63);
          if ((scan == path_len && emit_i == 7'd63) ||
              (scan != path_len && emit_i[5:0] == 6'(scan - path_len - 7'd1))) begin
            state <= S_WAIT;
          end else begin
            emit_i <= (emit_i == 7'd63) ? 7'd0 : emit_i + 7'd1;
            state <= S_EMITR;
          end
        end
        S_FAIL: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data <= '{path_row: 3'd0, path_col: 3'd0, found: 1'b0, last: 1'b1};
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Queue counts never pass the memory depth.
  a_fq_bound: assert property (@(posedge clk) disable iff (rst) fq_cnt <= 7'd64)
    else $error("forward queue overflow");
  a_bq_bound: assert property (@(posedge clk) disable iff (rst) bq_cnt <= 7'd64)
    else $error("backward queue overflow");
  // No new item while a result waits.
  a_no_take: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken with result pending");

endmodule

FILE: tb/sv/grid_bidirectional_path_search_tb.sv
// Self-checking testbench for grid_bidirectional_path_search: grid writes and path searches.
// Depends on gbps_pkg and the block; a scoreboard class predicts each search's path cells.
module grid_bidirectional_path_search_tb;
  import gbps_pkg::*;

  // Path predictor and store of expected path cells.
  class path_scoreboard;
    logic [3:0] grid_code [64];
    out_item_t  path_q [$];
    int         errors;

    function new();
      foreach (grid_code[i]) grid_code[i] = 4'd0;
      errors = 0;
    endfunction

    function bit open_cell(int idx);
      return (grid_code[idx] == 4'd0) || (grid_code[idx] == WALK_CODE);
    endfunction

    function int manhattan(int a, int b);
      int dr, dc;
      dr = a / 8 - b / 8;
      dc = a % 8 - b % 8;
      if (dr < 0) dr = -dr;
      if (dc < 0) dc = -dc;
      return dr + dc;
    endfunction

    function void push_fail();
      out_item_t o;
      o = '0;
      o.last = 1'b1;
      path_q = {path_q, o};
    endfunction

    // Note an accepted input: update the grid or predict the search results.
    function void note_input(in_item_t it);
      int start, goal, meet, side, cur, nc, k, best, x, n;
      int nbr [4];
      bit [6:0] fpar [64];
      bit [6:0] bpar [64];
      int qcell [2][64];
      int qcost [2][64];
      bit qtaken [2][64];
      int qcnt [2];
      int popped [2];
      int tmp [64];
      int path [$];
      out_item_t o;
      if (it.command == CMD_WRITE) begin
        grid_code[{it.cell_row, it.cell_col}] = it.cell_code;
        return;
      end
      start = {it.cell_row, it.cell_col};
      goal = {it.goal_row, it.goal_col};
      if (start == goal) begin
        push_fail();
        return;
      end
      foreach (fpar[i]) begin
        fpar[i] = '0;
        bpar[i] = '0;
      end
      qcnt[0] = 1; qcell[0][0] = start; qcost[0][0] = 0; qtaken[0][0] = 0;
      qcnt[1] = 1; qcell[1][0] = goal; qcost[1][0] = 0; qtaken[1][0] = 0;
      fpar[start] = {1'b1, 6'(start)};
      bpar[goal] = {1'b1, 6'(goal)};
      meet = -1;
      while (meet < 0) begin
        // Pop both frontiers: lowest cost, earliest insertion on ties.
        for (side = 0; side < 2; side++) begin
          best = -1;
          for (k = 0; k < qcnt[side]; k++)
            if (!qtaken[side][k] && (best < 0 || qcost[side][k] < qcost[side][best]))
              best = k;
          if (best < 0) begin
            push_fail();
            return;
          end
          qtaken[side][best] = 1'b1;
          popped[side] = qcell[side][best];
        end
        // Expand forward cell, then backward cell; up, left, right, down.
        for (side = 0; side < 2 && meet < 0; side++) begin
          cur = popped[side];
          n = 0;
          if (cur / 8 > 0 && open_cell(cur - 8)) nbr[n++] = cur - 8;
          if (cur % 8 > 0 && open_cell(cur - 1)) nbr[n++] = cur - 1;
          if (cur % 8 < 7 && open_cell(cur + 1)) nbr[n++] = cur + 1;
          if (cur / 8 < 7 && open_cell(cur + 8)) nbr[n++] = cur + 8;
          for (k = 0; k < n && meet < 0; k++) begin
            nc = nbr[k];
            if (side == 0) begin
              if (!fpar[nc][6]) begin
                qcell[0][qcnt[0]] = nc; qcost[0][qcnt[0]] = manhattan(nc, goal);
                qtaken[0][qcnt[0]] = 0; qcnt[0]++;
                fpar[nc] = {1'b1, 6'(cur)};
              end
              if (bpar[nc][6]) meet = nc;
            end else begin
              if (!bpar[nc][6]) begin
                qcell[1][qcnt[1]] = nc; qcost[1][qcnt[1]] = manhattan(nc, start);
                qtaken[1][qcnt[1]] = 0; qcnt[1]++;
                bpar[nc] = {1'b1, 6'(cur)};
              end
              if (fpar[nc][6]) meet = nc;
            end
          end
        end
      end
      // Path: forward chain back to the start reversed, then backward chain to the goal.
      n = 0;
      x = meet;
      while (int'(fpar[x][5:0]) != x && n < 64) begin
        tmp[n++] = x;
        x = fpar[x][5:0];
      end
      for (k = n - 1; k >= 0; k--) path = {path, tmp[k]};
      x = meet;
      while (x != goal && path.size() < 64) begin
        x = bpar[x][5:0];
        path = {path, x};
      end
      if (path.size() == 0) begin
        push_fail();
        return;
      end
      foreach (path[i]) begin
        o.path_row = 3'(path[i] / 8);
        o.path_col = 3'(path[i] % 8);
        o.found = 1'b1;
        o.last = (i == path.size() - 1);
        path_q = {path_q, o};
      end
    endfunction

    // Check one accepted result against the oldest expected path cell.
    function void check_result(out_item_t got);
      out_item_t want;
      if (path_q.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      want = path_q.pop_front();
      if (got.path_row !== want.path_row) begin
        $error("path_row expected %0d actual %0d", want.path_row, got.path_row);
        errors++;
      end
      if (got.path_col !== want.path_col) begin
        $error("path_col expected %0d actual %0d", want.path_col, got.path_col);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found expected %0d actual %0d", want.found, got.found);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  path_scoreboard sb = new();
  bit hold_out = 1'b0;
  int burst_left = 0;
  int idle_cycles = 0;

  grid_bidirectional_path_search dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Receiver: stalls on its own pattern, with one long hold-off on request.
  always @(posedge clk) begin
    int hold_cnt;
    if (hold_out) begin
      out_ready <= 1'b0;
      for (hold_cnt = 0; hold_cnt < 4000; hold_cnt++) @(posedge clk);
      hold_out = 1'b0;
    end else if ($urandom_range(0, 99) < 50) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles > 200000) begin
      $display("grid_bidirectional_path_search_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item and hold it until the transfer; gaps fall between bursts.
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic write_cell(int r, int c, int code);
    in_item_t it;
    it = in_item_t'($urandom);
    it.command = CMD_WRITE;
    it.cell_row = 3'(r);
    it.cell_col = 3'(c);
    it.cell_code = 4'(code);
    send_item(it);
  endtask

  task automatic search_path(int sr, int sc, int gr, int gc);
    in_item_t it;
    it = in_item_t'($urandom);
    it.command = CMD_SEARCH;
    it.cell_row = 3'(sr);
    it.cell_col = 3'(sc);
    it.goal_row = 3'(gr);
    it.goal_col = 3'(gc);
    send_item(it);
  endtask

  // Let the block drain and finish any write still in progress.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.path_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int i, kind;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: open grid corner to corner, both diagonals, start equals goal, adjacent cells.
    search_path(0, 0, 7, 7);
    search_path(7, 7, 0, 0);
    search_path(7, 0, 0, 7);
    search_path(3, 3, 3, 3);
    search_path(2, 2, 2, 3);
    // Wall across column 4 except a gap coded 9, then the walkable code.
    for (i = 0; i < 7; i++) write_cell(i, 4, 15);
    write_cell(7, 4, 9);
    search_path(0, 0, 0, 7);
    // Close the gap: a frontier empties.
    write_cell(7, 4, 1);
    search_path(0, 0, 0, 7);
    // Start and goal on walls still search from them.
    search_path(3, 4, 5, 4);
    for (i = 0; i < 8; i++) write_cell(i, 4, 0);
    drain();

    // Long receiver hold-off while the sender keeps offering items.
    hold_out = 1'b1;
    for (i = 0; i < 6; i++) search_path($urandom_range(0, 7), 0, $urandom_range(0, 7), 7);

    // Random: scattered walls with mostly well-formed searches.
    for (i = 0; i < 410; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        write_cell($urandom_range(0, 7), $urandom_range(0, 7),
                   $urandom_range(0, 2) != 0 ? ($urandom_range(0, 1) ? 0 : 9)
                                             : $urandom_range(0, 15));
      end else if (kind < 50) begin
        search_path($urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 7), $urandom_range(0, 7));
      end else begin
        search_path($urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 7), $urandom_range(0, 7));
      end
      if (i == 200) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.path_q.size() == 0) begin
      $display("grid_bidirectional_path_search_tb OK");
    end else begin
      $display("grid_bidirectional_path_search_tb NOT OK");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/gbps_pkg.sv
rtl/core/grid_bidirectional_path_search.sv
tb/sv/grid_bidirectional_path_search_tb.sv
